### rtl/epoc_pkg.sv
// Package for the encoding pattern overlap checker.
// Holds the stored-entry and result word types and the table constants.
// No dependencies.
package epoc_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	// Results per item, closing status included.
	localparam int RESULT_LIMIT    = 64;
	localparam int NCONF_W         = $clog2(RESULT_LIMIT);

	typedef struct packed {
		logic [63:0] mask;
		logic [63:0] value;
		logic [7:0]  priority_lvl;
		logic        guard;
		logic [15:0] id;
	} entry_t;

	typedef struct packed {
		logic        is_conflict;
		logic [15:0] first_instruction;
		logic [15:0] second_instruction;
		logic [63:0] witness_word;
		logic        table_overflow;
		logic        last_result;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CLOSE
	} scan_state_t;

endpackage

### rtl/encoding_pattern_overlap_checker_top.sv
// Top level of the encoding pattern overlap checker.
// Depends on epoc_pkg, epoc_table and epoc_scan; holds the output register.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one pattern word: mask, value,
//   priority, guard flag, instruction id, and start_set to begin a new set.
//   Output channel (out_valid / out_stall) returns zero or more conflict words
//   (is_conflict = 1) followed by one closing word (last_result = 1) that
//   flags table_overflow when the store was full and the pattern dropped.
//   Timing: one entry of the pattern store is read and compared per cycle,
//   set by its single read port, while no conflict word is stalled. Conflict
//   words enter the output register in store order, then the closing word;
//   with an empty store or start_set only the closing word is sent. A new
//   item is taken in the cycle after the closing word enters the output
//   register.
//   Stall: a stalled conflict word freezes the scan in place; nothing is lost.
//   Reset: empties the store (fill count to zero) and the output register;
//   store contents are not cleared and are never read before being written.
module encoding_pattern_overlap_checker_top #(
	parameter int TABLE_DEPTH = epoc_pkg::TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        start_set,
	input  logic [63:0] pattern_mask,
	input  logic [63:0] pattern_value,
	input  logic [7:0]  pattern_priority,
	input  logic        has_guards,
	input  logic [15:0] instruction_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_conflict,
	output logic [15:0] first_instruction,
	output logic [15:0] second_instruction,
	output logic [63:0] witness_word,
	output logic        table_overflow,
	output logic        last_result
);
	import epoc_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	entry_t        in_entry;
	entry_t        wr_data, rd_data;
	logic          wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic          push, can_push;
	result_t       res, out_q;
	logic          out_valid_q;

	assign in_entry.mask         = pattern_mask;
	assign in_entry.value        = pattern_value;
	assign in_entry.priority_lvl = pattern_priority;
	assign in_entry.guard        = has_guards;
	assign in_entry.id           = instruction_id;

	epoc_table #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	epoc_scan #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.start_set (start_set),
		.in_entry  (in_entry),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.can_push  (can_push),
		.push      (push),
		.res       (res)
	);

	// Output word register; refilled in the cycle it drains.
	assign can_push = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_push) begin
			out_valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (can_push && push) begin
			out_q <= res;
		end
	end

	assign out_valid          = out_valid_q;
	assign is_conflict        = out_q.is_conflict;
	assign first_instruction  = out_q.first_instruction;
	assign second_instruction = out_q.second_instruction;
	assign witness_word       = out_q.witness_word;
	assign table_overflow     = out_q.table_overflow;
	assign last_result        = out_q.last_result;

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		push && out_valid_q && out_stall |-> !can_push)
		else $error("word pushed into a held output register");
	a_close_before_next: assert property (@(posedge clk) disable iff (!arst_n)
		push && last_result == 1'b0 && res.last_result && can_push |=> !in_stall)
		else $error("closing word did not release the input");
	a_overflow_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.table_overflow |-> out_q.last_result)
		else $error("overflow flag on a conflict word");

endmodule

### rtl/epoc_table.sv
// Pattern store: one write port, one read port, registered read data.
// Depends on epoc_pkg for the entry word type.
module epoc_table #(
	parameter int DEPTH = epoc_pkg::TABLE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  epoc_pkg::entry_t wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output epoc_pkg::entry_t rd_data
);
	import epoc_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read data holds while no read is issued, so a stalled compare keeps its operand.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/epoc_scan.sv
// Scan sequencer: latches one pattern, walks the store one entry per cycle
// unless stalled, emits conflict words, then closes and stores it if room.
// Depends on epoc_pkg; drives epoc_table.
module epoc_scan #(
	parameter int DEPTH = epoc_pkg::TABLE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              start_set,
	input  epoc_pkg::entry_t  in_entry,
	output logic              wr_en,
	output logic [AW-1:0]     wr_addr,
	output epoc_pkg::entry_t  wr_data,
	output logic              rd_en,
	output logic [AW-1:0]     rd_addr,
	input  epoc_pkg::entry_t  rd_data,
	input  logic              can_push,
	output logic              push,
	output epoc_pkg::result_t res
);
	import epoc_pkg::*;

	scan_state_t        state_q, state_d;
	entry_t             item_q;
	logic [AW-1:0]      idx_q;
	logic [CW-1:0]      count_q;
	logic [NCONF_W-1:0] nconf_q;

	logic accept;
	logic full;
	logic last_idx;
	logic overlap, same_prio, refine_a, refine_b, no_guard, match, emit;
	logic [63:0] both_mask;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign full     = (count_q == CW'(DEPTH));
	assign last_idx = ((CW'(idx_q) + CW'(1)) == count_q);

	// Pair test between the stored entry and the latched pattern.
	always_comb begin
		both_mask = rd_data.mask & item_q.mask;
		overlap   = ((rd_data.value ^ item_q.value) & both_mask) == 64'd0;
		same_prio = (rd_data.priority_lvl == item_q.priority_lvl);
		refine_a  = (both_mask == item_q.mask) && (rd_data.mask != item_q.mask);
		refine_b  = (both_mask == rd_data.mask) && (rd_data.mask != item_q.mask);
		no_guard  = !rd_data.guard && !item_q.guard;
		match     = overlap && same_prio && !refine_a && !refine_b && no_guard;
		// Beyond the record limit further hits are dropped.
		emit      = match && (nconf_q != NCONF_W'(RESULT_LIMIT - 1));
	end

	assign wr_addr = count_q[AW-1:0];
	assign wr_data = item_q;

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = idx_q;
		wr_en   = 1'b0;
		push    = 1'b0;
		res     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (start_set || (count_q == '0)) begin
						state_d = ST_CLOSE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = '0;
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				res.is_conflict        = 1'b1;
				res.first_instruction  = rd_data.id;
				res.second_instruction = item_q.id;
				res.witness_word       = (rd_data.value & rd_data.mask) |
				                         (item_q.value & item_q.mask);
				if (!emit || can_push) begin
					push = emit;
					if (last_idx) begin
						state_d = ST_CLOSE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_q + AW'(1);
					end
				end
			end
			ST_CLOSE: begin
				res.table_overflow = full;
				res.last_result    = 1'b1;
				if (can_push) begin
					push    = 1'b1;
					wr_en   = !full;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			nconf_q <= '0;
			idx_q   <= '0;
		end else begin
			if (accept && start_set) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + CW'(1);
			end
			if (accept) begin
				nconf_q <= '0;
			end else if (push && res.is_conflict) begin
				nconf_q <= nconf_q + NCONF_W'(1);
			end
			if (rd_en) begin
				idx_q <= rd_addr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_entry;
		end
	end

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> count_q != '0)
		else $error("scan with empty store");
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> CW'(idx_q) < count_q)
		else $error("scan index past fill count");
	a_conf_limit: assert property (@(posedge clk) disable iff (!arst_n)
		push && res.is_conflict |-> nconf_q != NCONF_W'(RESULT_LIMIT - 1))
		else $error("conflict record past limit");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count above depth");
	a_write_only_close: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == ST_CLOSE && push && !full)
		else $error("store write outside closing step");

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Testbench for encoding_pattern_overlap_checker_top: ternary pattern words go in,
// and a scoreboard predicts each conflict word and each closing word.
// Depends on epoc_pkg and the RTL only.
module testbench;
	import epoc_pkg::*;

	localparam logic [63:0] ALL_ONES = '1;
	localparam int QUIET_LIMIT = 3000;

	class overlap_scoreboard;
		entry_t store[];
		int depth;
		int fill;
		int failures;
		result_t owed_words[$];

		function new(int d);
			depth = d;
			store = new[d];
			fill = 0;
			failures = 0;
		endfunction

		function bit strictly_covers(logic [63:0] wide, logic [63:0] narrow);
			return ((wide & narrow) == narrow) && (wide != narrow);
		endfunction

		// Scan the current set the way the block does, then append if there is room.
		function void note_pattern(bit fresh_set, entry_t p);
			result_t w;
			int hits;
			bit full;
			if (fresh_set)
				fill = 0;
			hits = 0;
			for (int i = 0; i < fill; i++) begin
				entry_t s;
				s = store[i];
				if (((s.value ^ p.value) & s.mask & p.mask) != 0)
					continue;
				if (s.priority_lvl != p.priority_lvl)
					continue;
				if (strictly_covers(s.mask, p.mask) || strictly_covers(p.mask, s.mask))
					continue;
				if (s.guard || p.guard)
					continue;
				// one slot is kept for the closing word
				if (hits >= RESULT_LIMIT - 1)
					break;
				w = '0;
				w.is_conflict = 1'b1;
				w.first_instruction = s.id;
				w.second_instruction = p.id;
				w.witness_word = (s.value & s.mask) | (p.value & p.mask);
				owed_words = {owed_words, w};
				hits++;
			end
			full = (fill >= depth);
			w = '0;
			w.table_overflow = full;
			w.last_result = 1'b1;
			owed_words = {owed_words, w};
			if (!full) begin
				store[fill] = p;
				fill++;
			end
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
				failures++;
			end
		endfunction

		function void check_word(result_t got);
			result_t want;
			if (owed_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h", $time, got);
				failures++;
				return;
			end
			want = owed_words.pop_front();
			compare_field("is_conflict", 64'(want.is_conflict), 64'(got.is_conflict));
			compare_field("first_instruction", 64'(want.first_instruction),
				64'(got.first_instruction));
			compare_field("second_instruction", 64'(want.second_instruction),
				64'(got.second_instruction));
			compare_field("witness_word", want.witness_word, got.witness_word);
			compare_field("table_overflow", 64'(want.table_overflow),
				64'(got.table_overflow));
			compare_field("last_result", 64'(want.last_result), 64'(got.last_result));
		endfunction

		function int words_owed();
			return owed_words.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        start_set = 1'b0;
	logic [63:0] pattern_mask = '0;
	logic [63:0] pattern_value = '0;
	logic [7:0]  pattern_priority = '0;
	logic        has_guards = 1'b0;
	logic [15:0] instruction_id = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        is_conflict;
	logic [15:0] first_instruction;
	logic [15:0] second_instruction;
	logic [63:0] witness_word;
	logic        table_overflow;
	logic        last_result;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	overlap_scoreboard sb;

	encoding_pattern_overlap_checker_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.start_set(start_set),
		.pattern_mask(pattern_mask),
		.pattern_value(pattern_value),
		.pattern_priority(pattern_priority),
		.has_guards(has_guards),
		.instruction_id(instruction_id),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.is_conflict(is_conflict),
		.first_instruction(first_instruction),
		.second_instruction(second_instruction),
		.witness_word(witness_word),
		.table_overflow(table_overflow),
		.last_result(last_result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Handshakes are sampled with pre-edge values; input first so its words are queued.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_pattern(start_set, entry_t'{pattern_mask, pattern_value,
				pattern_priority, has_guards, instruction_id});
		if (arst_n && out_valid && !out_stall)
			sb.check_word(result_t'{is_conflict, first_instruction, second_instruction,
				witness_word, table_overflow, last_result});
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_pattern(input bit fresh_set, input entry_t p);
		if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		start_set <= fresh_set;
		pattern_mask <= p.mask;
		pattern_value <= p.value;
		pattern_priority <= p.priority_lvl;
		has_guards <= p.guard;
		instruction_id <= p.id;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (sb.words_owed() != 0);
	endtask

	// One set of related patterns around a random base, so that many pairs overlap.
	task automatic run_set(input int len, input bit all_same);
		logic [63:0] bm;
		logic [63:0] bv;
		logic [63:0] sparse;
		logic [63:0] one_bit;
		logic [7:0] bp;
		entry_t p;
		bit fresh;
		int pick;
		case ($urandom_range(0, 2))
			0: bm = rand64() | rand64();
			1: bm = rand64();
			default: bm = rand64() & rand64();
		endcase
		bv = rand64();
		bp = 8'($urandom_range(0, 255));
		for (int k = 0; k < len; k++) begin
			fresh = (k == 0);
			sparse = rand64() & rand64() & rand64();
			one_bit = 64'd1 << $urandom_range(0, 63);
			pick = $urandom_range(0, 99);
			p.mask = bm;
			p.value = bv;
			if (!all_same) begin
				if (pick < 15) begin
					p.value = bv ^ (rand64() & ~bm);
				end else if (pick < 50) begin
					p.mask = bm ^ sparse;
				end else if (pick < 65) begin
					p.mask = $urandom_range(0, 1) ? (bm | sparse) : (bm & ~sparse);
				end else if (pick < 80) begin
					// clash on one constrained bit
					p.mask = bm | one_bit;
					p.value = bv ^ one_bit;
				end else begin
					p.mask = rand64();
					p.value = rand64();
					fresh = fresh || ($urandom_range(0, 3) == 0);
				end
			end
			p.priority_lvl = (all_same || $urandom_range(0, 99) < 85) ? bp :
				8'($urandom_range(0, 255));
			p.guard = !all_same && ($urandom_range(0, 9) == 0);
			p.id = 16'($urandom_range(0, 65535));
			send_pattern(fresh, p);
		end
	endtask

	task automatic run_phase(input int idle, input int stall, input int quota,
		input int long_len, input bit long_same);
		int sent;
		int len;
		send_idle_pct = idle;
		stall_pct = stall;
		sent = 0;
		if (long_len > 0) begin
			run_set(long_len, long_same);
			sent = long_len;
		end
		while (sent < quota) begin
			len = $urandom_range(1, 16);
			run_set(len, 1'b0);
			sent += len;
		end
		in_valid <= 1'b0;
		// hold off until every owed word is back
		wait_drained();
	endtask

	initial begin
		sb = new(TABLE_DEPTH_DEF);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pattern(1'b1, entry_t'{64'h0, 64'h0, 8'h00, 1'b0, 16'h0000});
		// both masks empty and equal: overlap with witness zero
		send_pattern(1'b0, entry_t'{64'h0, ALL_ONES, 8'h00, 1'b0, 16'hFFFF});
		send_pattern(1'b0, entry_t'{ALL_ONES, ALL_ONES, 8'h00, 1'b0, 16'h0001});
		send_pattern(1'b0, entry_t'{ALL_ONES, ALL_ONES, 8'h00, 1'b0, 16'h0002});
		send_pattern(1'b0, entry_t'{ALL_ONES, 64'h0, 8'h00, 1'b0, 16'h0003});
		send_pattern(1'b0, entry_t'{ALL_ONES, ALL_ONES, 8'hFF, 1'b0, 16'h0004});
		send_pattern(1'b0, entry_t'{ALL_ONES, ALL_ONES, 8'hFF, 1'b1, 16'h0005});
		send_pattern(1'b0, entry_t'{ALL_ONES, ALL_ONES, 8'hFF, 1'b0, 16'h0006});
		// disjoint masks, then one straddling both
		send_pattern(1'b1, entry_t'{64'h0000_0000_FFFF_FFFF, 64'hA5A5_A5A5_1234_5678,
			8'h80, 1'b0, 16'h8000});
		send_pattern(1'b0, entry_t'{64'hFFFF_FFFF_0000_0000, 64'hDEAD_BEEF_0F0F_0F0F,
			8'h80, 1'b0, 16'h7FFF});
		send_pattern(1'b0, entry_t'{64'h0000_FFFF_FFFF_0000, 64'h0000_BEEF_1234_0000,
			8'h80, 1'b0, 16'hC3C3});
		send_pattern(1'b1, entry_t'{64'h0000_FFFF_FFFF_0000, 64'h0000_BEEF_1234_0000,
			8'h80, 1'b0, 16'h3C3C});

		// identical long set overruns the store and the per-item word cap
		run_phase(0, 0, 70, 68, 1'b1);
		run_phase(87, 0, 70, 0, 1'b0);
		run_phase(0, 87, 70, 0, 1'b0);
		run_phase(35, 35, 80, 70, 1'b0);

		send_idle_pct = 0;
		stall_pct = 0;
		repeat (TABLE_DEPTH_DEF + 8) @(posedge clk);
		if (sb.words_owed() != 0) begin
			$display("%0t: %0d words never arrived, expected next %h", $time,
				sb.words_owed(), sb.owed_words[0]);
			sb.failures++;
		end
		if (sb.failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### sim.f
rtl/epoc_pkg.sv
rtl/epoc_table.sv
rtl/epoc_scan.sv
rtl/encoding_pattern_overlap_checker_top.sv
verif/testbench.sv
